// File: sv/ffrw_pkg.sv
// ----------------------------------------------------------------------------
// ffrw_pkg
// Shared types and codes of the arrival-ordered readers/writers lock arbiter.
// ----------------------------------------------------------------------------
package ffrw_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_CLIENTS_DEF = 128;
  // grants delivered for one request at most
  localparam int MAX_RESULTS     = 16;
  localparam int ID_W            = 7;
  localparam int COUNT_W         = 8;

  typedef enum logic [1:0] {
    ACT_REQ_READ  = 2'd0,
    ACT_REQ_WRITE = 2'd1,
    ACT_REL_READ  = 2'd2,
    ACT_REL_WRITE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_MISMATCH = 2'd2
  } err_t;

  // one waiting request
  typedef struct packed {
    logic            writer;
    logic [ID_W-1:0] id;
  } wait_ent_t;

  // one pending result
  typedef struct packed {
    logic            grant;
    logic            writer;
    logic [ID_W-1:0] id;
  } res_ent_t;

  // controls handed to a row of cells
  typedef struct packed {
    logic shift_en;
    logic wr_en;
  } chain_ctl_t;

endpackage

// File: sv/ffrw_cell.sv
// ----------------------------------------------------------------------------
// ffrw_cell
// One storage cell of a shifting row: loads its own write data or takes the
// word of its upper neighbor.
// ----------------------------------------------------------------------------
module ffrw_cell import ffrw_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  chain_ctl_t       ctl,
  input  logic [WIDTH-1:0] shift_in,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] data_r;

  // direct write wins, otherwise move one place toward the head
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      data_r <= wr_data;
    end else if (ctl.shift_en) begin
      data_r <= shift_in;
    end
  end

  assign q = data_r;

endmodule

// File: sv/ffrw_chain.sv
// ----------------------------------------------------------------------------
// ffrw_chain
// Row of cells with the head at cell 0. A write lands at one indexed cell,
// a shift moves every word one cell toward the head.
// ----------------------------------------------------------------------------
module ffrw_chain import ffrw_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  chain_ctl_t       ctl,
  input  logic [IW-1:0]    wr_idx,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    chain_ctl_t       cell_ctl;
    logic [WIDTH-1:0] up_q;

    // per-cell write decode
    assign cell_ctl.shift_en = ctl.shift_en;
    assign cell_ctl.wr_en    = ctl.wr_en && (wr_idx == IW'(i));
    // top cell holds its own word on a shift
    assign up_q = (i == DEPTH - 1) ? cell_q[i] : cell_q[(i == DEPTH - 1) ? i : i + 1];

    ffrw_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .shift_in (up_q),
      .wr_data  (wr_data),
      .q        (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule

// File: sv/fifo_fair_reader_writer_lock.sv
// ----------------------------------------------------------------------------
// fifo_fair_reader_writer_lock
// Readers/writers lock arbiter that grants waiting requests in arrival order.
// ----------------------------------------------------------------------------
// One request is handled at a time. It is first taken (immediate grant,
// queueing or release), then the wait queue, a row of cells with its head at
// cell 0, grants its head one per cycle while the lock and the result row allow
// it, and finally the results are shown one per cycle from a second row of cells
// while the consumer takes them. A request that ends in an error skips the
// drain. The consumer holding out_ready low stalls the result phase. Every
// result of one request carries the lock mode and reader count that hold after
// the whole request. No clearing pass is needed after reset.
module fifo_fair_reader_writer_lock import ffrw_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [ID_W-1:0]    in_requester_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_grant_valid,
  output logic [ID_W-1:0]    out_grant_id,
  output logic               out_grant_is_writer,
  output logic [1:0]         out_error_code,
  output logic [1:0]         out_lock_mode,
  output logic [COUNT_W-1:0] out_reader_count,
  output logic               out_last
);

  localparam int READER_CAP = (MAX_CLIENTS < 255) ? MAX_CLIENTS : 255;
  localparam int QCW        = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW        = $clog2(QUEUE_DEPTH);
  localparam int NW         = $clog2(MAX_RESULTS + 1);
  localparam int RIW        = $clog2(MAX_RESULTS);
  localparam int WE_W       = $bits(wait_ent_t);
  localparam int RE_W       = $bits(res_ent_t);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_DRAIN = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [COUNT_W-1:0] readers_r, readers_nxt;
  logic [QCW-1:0]     qcount_r, qcount_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  err_t               err_r, err_nxt;

  chain_ctl_t         q_ctl, r_ctl;
  logic [QIW-1:0]     q_idx;
  logic [RIW-1:0]     r_idx;
  wait_ent_t          q_wdata, q_head;
  res_ent_t           r_wdata, r_head;
  logic [WE_W-1:0]    q_head_raw;
  logic [RE_W-1:0]    r_head_raw;

  logic               q_empty, q_full, below_cap, room;

  assign q_head   = wait_ent_t'(q_head_raw);
  assign r_head   = res_ent_t'(r_head_raw);
  assign q_empty  = (qcount_r == '0);
  assign q_full   = (qcount_r == QCW'(QUEUE_DEPTH));
  assign below_cap = (readers_r < COUNT_W'(READER_CAP));
  assign room     = (n_r != NW'(MAX_RESULTS));

  // wait queue
  ffrw_chain #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (WE_W)
  ) u_wait_q (
    .clk     (clk),
    .ctl     (q_ctl),
    .wr_idx  (q_idx),
    .wr_data (q_wdata),
    .head    (q_head_raw)
  );

  // results of the current request
  ffrw_chain #(
    .DEPTH (MAX_RESULTS),
    .WIDTH (RE_W)
  ) u_res_q (
    .clk     (clk),
    .ctl     (r_ctl),
    .wr_idx  (r_idx),
    .wr_data (r_wdata),
    .head    (r_head_raw)
  );

  // request handling, drain and result sequencing
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    readers_nxt = readers_r;
    qcount_nxt  = qcount_r;
    n_nxt       = n_r;
    err_nxt     = err_r;
    q_ctl       = '0;
    q_idx       = qcount_r[QIW-1:0];
    q_wdata     = '{writer: 1'b0, id: in_requester_id};
    r_ctl       = '0;
    r_idx       = n_r[RIW-1:0];
    r_wdata     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt = ERR_OK;
          n_nxt   = '0;
          r_idx   = '0;
          case (action_t'(in_action))
            ACT_REQ_READ: begin
              if (q_empty && mode_r != MODE_WRITE && below_cap) begin
                mode_nxt      = MODE_READ;
                readers_nxt   = readers_r + 1'b1;
                r_ctl.wr_en   = 1'b1;
                r_wdata       = '{grant: 1'b1, writer: 1'b0, id: in_requester_id};
                n_nxt         = NW'(1);
              end else if (q_full) begin
                err_nxt = ERR_FULL;
              end else begin
                q_ctl.wr_en = 1'b1;
                qcount_nxt  = qcount_r + 1'b1;
              end
            end
            ACT_REQ_WRITE: begin
              if (mode_r == MODE_IDLE && q_empty) begin
                mode_nxt    = MODE_WRITE;
                r_ctl.wr_en = 1'b1;
                r_wdata     = '{grant: 1'b1, writer: 1'b1, id: in_requester_id};
                n_nxt       = NW'(1);
              end else if (q_full) begin
                err_nxt = ERR_FULL;
              end else begin
                q_ctl.wr_en = 1'b1;
                q_wdata     = '{writer: 1'b1, id: in_requester_id};
                qcount_nxt  = qcount_r + 1'b1;
              end
            end
            ACT_REL_READ: begin
              if (mode_r != MODE_READ || readers_r == '0) begin
                err_nxt = ERR_MISMATCH;
              end else begin
                readers_nxt = readers_r - 1'b1;
                if (readers_r == COUNT_W'(1)) begin
                  mode_nxt = MODE_IDLE;
                end
              end
            end
            ACT_REL_WRITE: begin
              if (mode_r != MODE_WRITE) begin
                err_nxt = ERR_MISMATCH;
              end else begin
                mode_nxt = MODE_IDLE;
              end
            end
            default: begin
              err_nxt = ERR_MISMATCH;
            end
          endcase
          // an error gives a lone status result
          if (err_nxt != ERR_OK) begin
            r_ctl.wr_en = 1'b1;
            r_wdata     = '0;
            n_nxt       = NW'(1);
            state_nxt   = S_EMIT;
          end else begin
            state_nxt = S_DRAIN;
          end
        end
      end

      S_DRAIN: begin
        // grant the queue head while the lock allows it
        if (room && !q_empty &&
            (mode_r == MODE_IDLE ||
             (mode_r == MODE_READ && !q_head.writer && below_cap))) begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt    = q_head.writer ? MODE_WRITE : MODE_READ;
            readers_nxt = q_head.writer ? '0 : COUNT_W'(1);
          end else begin
            readers_nxt = readers_r + 1'b1;
          end
          q_ctl.shift_en = 1'b1;
          qcount_nxt     = qcount_r - 1'b1;
          r_ctl.wr_en    = 1'b1;
          r_wdata        = '{grant: 1'b1, writer: q_head.writer, id: q_head.id};
          n_nxt          = n_r + 1'b1;
        end else begin
          // nothing granted at all: one status result
          if (n_r == '0) begin
            r_ctl.wr_en = 1'b1;
            r_wdata     = '0;
            n_nxt       = NW'(1);
          end
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_ready) begin
          r_ctl.shift_en = 1'b1;
          n_nxt          = n_r - 1'b1;
          if (n_r == NW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= MODE_IDLE;
      readers_r <= '0;
      qcount_r  <= '0;
      n_r       <= '0;
      err_r     <= ERR_OK;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      readers_r <= readers_nxt;
      qcount_r  <= qcount_nxt;
      n_r       <= n_nxt;
      err_r     <= err_nxt;
    end
  end

  // ports
  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = (state_r == S_EMIT);
  assign out_grant_valid     = r_head.grant;
  assign out_grant_id        = r_head.id;
  assign out_grant_is_writer = r_head.writer;
  assign out_error_code      = err_r;
  assign out_lock_mode       = mode_r;
  assign out_reader_count    = readers_r;
  assign out_last            = (n_r == NW'(1));

  // checks
  a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r <= QCW'(QUEUE_DEPTH))
    else $error("wait queue count beyond depth");

  a_idle_no_readers: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_IDLE |-> readers_r == '0)
    else $error("readers counted while lock idle");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> n_r != '0)
    else $error("result phase with no pending result");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("block busy after final result");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_OK |-> out_last && !out_grant_valid)
    else $error("error result not a lone status result");

endmodule
